/* design/usm_pkg.sv */
package usm_pkg;

	// sizing
	localparam int MAX_CORNERS    = 16;
	localparam int CORNER_ID_BITS = 24;
	localparam int IDX_W          = $clog2(MAX_CORNERS);
	localparam int CNT_W          = $clog2(MAX_CORNERS + 1);

	// field widths
	localparam int UV_W  = 32;
	localparam int TAN_W = 32;
	localparam int SUM_W = TAN_W + $clog2(MAX_CORNERS);
	localparam int TOL_W = 24;
	localparam int Q_W   = 16;

	// normalisation widths
	localparam int MAG_W  = 30;
	localparam int SH_MAX = SUM_W - MAG_W;
	localparam int SH_W   = $clog2(SH_MAX + 1);
	localparam int SQ_W   = 2 * MAG_W + 2;
	localparam int LEN_W  = MAG_W + 1;
	localparam int DIV_W  = LEN_W + Q_W - 1;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(168);

	// corner under test, broadcast to every cell
	typedef struct packed {
		logic signed [UV_W-1:0]  u;
		logic signed [UV_W-1:0]  v;
		logic signed [TAN_W-1:0] tx;
		logic signed [TAN_W-1:0] ty;
		logic signed [TAN_W-1:0] tz;
	} cand_t;

	// one group slot
	typedef struct packed {
		logic signed [UV_W-1:0]  u;
		logic signed [UV_W-1:0]  v;
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
	} grp_t;

	typedef struct packed {
		logic hit_en;
		logic open;
		logic add;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] qx;
		logic signed [Q_W-1:0] qy;
		logic signed [Q_W-1:0] qz;
	} norm_res_t;

endpackage

/* design/usm_cell.sv */
module usm_cell import usm_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  cand_t            cand,
	input  logic [TOL_W-1:0] tol,
	input  grp_t             nbr,
	output grp_t             grp,
	output logic             hit
);

	grp_t                 grp_q;
	logic                 hit_q;
	logic signed [UV_W:0] du;
	logic signed [UV_W:0] dv;
	logic [UV_W:0]        adu;
	logic [UV_W:0]        adv;
	logic [UV_W+1:0]      uv_dist;

	// manhattan distance from the stored group uv
	always_comb begin
		du      = {grp_q.u[UV_W-1], grp_q.u} - {cand.u[UV_W-1], cand.u};
		dv      = {grp_q.v[UV_W-1], grp_q.v} - {cand.v[UV_W-1], cand.v};
		adu     = du[UV_W] ? (UV_W+1)'(-du) : (UV_W+1)'(du);
		adv     = dv[UV_W] ? (UV_W+1)'(-dv) : (UV_W+1)'(dv);
		uv_dist = {1'b0, adu} + {1'b0, adv};
	end

	// slot update: shift from neighbour, open, or accumulate
	always_ff @(posedge clk) begin
		if (ctl.hit_en) begin
			hit_q <= uv_dist < (UV_W+2)'(tol);
		end
		if (ctl.shift) begin
			grp_q <= nbr;
		end else if (ctl.open) begin
			grp_q.u  <= cand.u;
			grp_q.v  <= cand.v;
			grp_q.sx <= {{(SUM_W-TAN_W){cand.tx[TAN_W-1]}}, cand.tx};
			grp_q.sy <= {{(SUM_W-TAN_W){cand.ty[TAN_W-1]}}, cand.ty};
			grp_q.sz <= {{(SUM_W-TAN_W){cand.tz[TAN_W-1]}}, cand.tz};
		end else if (ctl.add) begin
			grp_q.sx <= grp_q.sx + {{(SUM_W-TAN_W){cand.tx[TAN_W-1]}}, cand.tx};
			grp_q.sy <= grp_q.sy + {{(SUM_W-TAN_W){cand.ty[TAN_W-1]}}, cand.ty};
			grp_q.sz <= grp_q.sz + {{(SUM_W-TAN_W){cand.tz[TAN_W-1]}}, cand.tz};
		end
	end

	assign grp = grp_q;
	assign hit = hit_q;

endmodule

/* design/usm_norm.sv */
module usm_norm import usm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] sx,
	input  logic signed [SUM_W-1:0] sy,
	input  logic signed [SUM_W-1:0] sz,
	output norm_res_t               res
);

	typedef enum logic [2:0] {
		N_IDLE, N_MAG, N_SQ, N_SQRT, N_DINIT, N_DSTEP
	} nstate_t;

	localparam logic [SUM_W-1:0] MAG_LIM  = SUM_W'(1) << MAG_W;
	localparam logic [SQ_W-1:0]  BIT_INIT = SQ_W'(1) << (SQ_W - 2);

	nstate_t              state_q;
	logic [SUM_W-1:0]     mag_q [3];
	logic [2:0]           neg_q;
	logic [MAG_W-1:0]     m_q [3];
	logic [1:0]           k_q;
	logic [SQ_W-1:0]      n_q;
	logic [SQ_W-1:0]      res_q;
	logic [SQ_W-1:0]      bit_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [Q_W-1:0]       quo_q;
	logic [$clog2(Q_W)-1:0] step_q;
	logic signed [Q_W-1:0] q_q [3];
	logic                 done_q;

	logic [SUM_W-1:0]     mx;
	logic [SH_W-1:0]      sh;
	logic [2*MAG_W-1:0]   prod;
	logic [SQ_W-1:0]      trial;
	logic [LEN_W-1:0]     len;
	logic [Q_W-1:0]       quo_nx;
	logic [Q_W-1:0]       qsat;
	logic                 fin;

	// largest magnitude and the shift that brings it under range
	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
		sh = '0;
		for (int i = SH_MAX; i >= 0; i--) begin
			if ((mx >> i) < MAG_LIM) sh = SH_W'(i);
		end
	end

	// datapath helpers
	always_comb begin
		prod   = m_q[k_q] * m_q[k_q];
		trial  = res_q + bit_q;
		len    = res_q[LEN_W-1:0];
		quo_nx = {quo_q[Q_W-2:0], rem_q >= dvs_q};
		if (neg_q[k_q]) begin
			qsat = Q_W'(-quo_nx);
		end else if (quo_nx[Q_W-1]) begin
			qsat = {1'b0, {(Q_W-1){1'b1}}};
		end else begin
			qsat = quo_nx;
		end
		fin = ((state_q == N_MAG) && (mx == '0))
			|| ((state_q == N_DSTEP) && (step_q == {$clog2(Q_W){1'b1}}) && (k_q == 2'd2));
	end

	// sequencer: magnitudes, sum of squares, root, three divides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						mag_q[0] <= sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
						mag_q[1] <= sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
						mag_q[2] <= sz[SUM_W-1] ? SUM_W'(-sz) : SUM_W'(sz);
						neg_q    <= {sz[SUM_W-1], sy[SUM_W-1], sx[SUM_W-1]};
						state_q  <= N_MAG;
					end
				end
				N_MAG: begin
					if (mx == '0) begin
						q_q[0]  <= '0;
						q_q[1]  <= '0;
						q_q[2]  <= '0;
						state_q <= N_IDLE;
					end else begin
						for (int i = 0; i < 3; i++) m_q[i] <= MAG_W'(mag_q[i] >> sh);
						n_q     <= '0;
						k_q     <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					n_q <= n_q + SQ_W'(prod);
					if (k_q == 2'd2) begin
						res_q   <= '0;
						bit_q   <= BIT_INIT;
						state_q <= N_SQRT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				N_SQRT: begin
					if (n_q >= trial) begin
						n_q   <= n_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == SQ_W'(1)) begin
						k_q     <= '0;
						state_q <= N_DINIT;
					end
				end
				N_DINIT: begin
					rem_q   <= {1'b0, m_q[k_q], {(Q_W-1){1'b0}}} + DIV_W'(len >> 1);
					dvs_q   <= {len, {(Q_W-1){1'b0}}};
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= N_DSTEP;
				end
				N_DSTEP: begin
					if (rem_q >= dvs_q) rem_q <= rem_q - dvs_q;
					dvs_q  <= dvs_q >> 1;
					quo_q  <= quo_nx;
					step_q <= step_q + 1'b1;
					if (step_q == {$clog2(Q_W){1'b1}}) begin
						q_q[k_q] <= qsat;
						if (k_q == 2'd2) begin
							state_q <= N_IDLE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= N_DINIT;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.qx   = q_q[0];
	assign res.qy   = q_q[1];
	assign res.qz   = q_q[2];

endmodule

/* design/uv_seam_tangent_merge.sv */
// Merges the face corners of one vertex into UV groups and returns one
// normalised Q1.15 tangent per corner. Each corner item is registered,
// matched in parallel in the group cells and then applied to them, and the
// block takes no new item meanwhile. On the item marked last_corner the
// vertex is flushed: for every group, normalisation runs 3 squaring steps,
// 31 root steps and three 16-step divides, then the corner store is scanned
// at one corner per cycle while the output is not stalled. Input stays
// blocked until the store has been scanned for the last group. Corners
// beyond the store depth are dropped but a dropped last corner still
// flushes the vertex.
module uv_seam_tangent_merge import usm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [TOL_W-1:0]          cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CORNER_ID_BITS-1:0] corner_index,
	input  logic signed [UV_W-1:0]    uv_u,
	input  logic signed [UV_W-1:0]    uv_v,
	input  logic signed [TAN_W-1:0]   tri_tangent_x,
	input  logic signed [TAN_W-1:0]   tri_tangent_y,
	input  logic signed [TAN_W-1:0]   tri_tangent_z,
	input  logic                      last_corner,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CORNER_ID_BITS-1:0] out_corner_index,
	output logic signed [Q_W-1:0]     tangent_x,
	output logic signed [Q_W-1:0]     tangent_y,
	output logic signed [Q_W-1:0]     tangent_z,
	output logic                      last_result
);

	typedef enum logic [2:0] {
		S_IDLE, S_MATCH, S_UPDATE, S_NSTART, S_NWAIT, S_EMIT, S_NEXT
	} state_t;

	state_t                    state_q;
	logic [TOL_W-1:0]          tol_q;
	cand_t                     cand_s1;
	logic [CORNER_ID_BITS-1:0] id_s1;
	logic                      last_s1;
	logic [CNT_W-1:0]          gcount_q;
	logic [CNT_W-1:0]          ccount_q;
	logic [CNT_W-1:0]          gsel_q;
	logic [CNT_W-1:0]          scan_q;
	logic [IDX_W-1:0]          lastc_q;
	logic [CORNER_ID_BITS-1:0] sid_q [MAX_CORNERS];
	logic [IDX_W-1:0]          sgrp_q [MAX_CORNERS];
	logic                      out_valid_q;
	logic [CORNER_ID_BITS-1:0] out_id_q;
	logic signed [Q_W-1:0]     out_x_q;
	logic signed [Q_W-1:0]     out_y_q;
	logic signed [Q_W-1:0]     out_z_q;
	logic                      out_last_q;

	cell_ctl_t                 ctl [MAX_CORNERS];
	grp_t                      grp [MAX_CORNERS];
	grp_t                      nbr [MAX_CORNERS];
	logic [MAX_CORNERS-1:0]    hit;
	logic [IDX_W-1:0]          found;
	logic                      found_any;
	logic                      upd;
	logic [IDX_W-1:0]          ent;
	logic                      ent_match;
	logic                      out_free;
	logic                      load_out;
	norm_res_t                 nres;

	// first matching live group
	always_comb begin
		found     = '0;
		found_any = 1'b0;
		for (int i = MAX_CORNERS - 1; i >= 0; i--) begin
			if (hit[i] && (CNT_W'(i) < gcount_q)) begin
				found     = IDX_W'(i);
				found_any = 1'b1;
			end
		end
		upd = (state_q == S_UPDATE) && (ccount_q != CNT_W'(MAX_CORNERS));
	end

	// per-cell control and neighbour links
	always_comb begin
		for (int i = 0; i < MAX_CORNERS; i++) begin
			ctl[i].hit_en = state_q == S_MATCH;
			ctl[i].open   = upd && !found_any && (CNT_W'(i) == gcount_q);
			ctl[i].add    = upd && found_any && (found == IDX_W'(i));
			ctl[i].shift  = state_q == S_NEXT;
			nbr[i]        = (i == MAX_CORNERS - 1) ? '0 : grp[(i + 1) % MAX_CORNERS];
		end
	end

	// row of group cells
	for (genvar gi = 0; gi < MAX_CORNERS; gi++) begin : g_cell
		usm_cell u_cell (
			.clk  (clk),
			.ctl  (ctl[gi]),
			.cand (cand_s1),
			.tol  (tol_q),
			.nbr  (nbr[gi]),
			.grp  (grp[gi]),
			.hit  (hit[gi])
		);
	end

	// normalisation of the group at the head of the row
	usm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_NSTART),
		.sx     (grp[0].sx),
		.sy     (grp[0].sy),
		.sz     (grp[0].sz),
		.res    (nres)
	);

	assign ent       = scan_q[IDX_W-1:0];
	assign ent_match = sgrp_q[ent] == gsel_q[IDX_W-1:0];
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == S_EMIT) && (scan_q != ccount_q) && ent_match && out_free;

	// corner store
	always_ff @(posedge clk) begin
		if (upd) begin
			sid_q[ccount_q[IDX_W-1:0]]  <= id_s1;
			sgrp_q[ccount_q[IDX_W-1:0]] <= found_any ? found : gcount_q[IDX_W-1:0];
		end
	end

	// incoming item register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cand_s1.u  <= uv_u;
			cand_s1.v  <= uv_v;
			cand_s1.tx <= tri_tangent_x;
			cand_s1.ty <= tri_tangent_y;
			cand_s1.tz <= tri_tangent_z;
			id_s1      <= corner_index;
			last_s1    <= last_corner;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tol_q       <= TOL_RESET;
			gcount_q    <= '0;
			ccount_q    <= '0;
			gsel_q      <= '0;
			scan_q      <= '0;
			lastc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) tol_q <= cfg_wr_data;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MATCH;
				end
				S_MATCH: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (upd) begin
						ccount_q <= ccount_q + 1'b1;
						if (!found_any) gcount_q <= gcount_q + 1'b1;
						if (!found_any || (CNT_W'(found) + 1'b1 == gcount_q)) begin
							lastc_q <= ccount_q[IDX_W-1:0];
						end
					end
					gsel_q  <= '0;
					state_q <= last_s1 ? S_NSTART : S_IDLE;
				end
				S_NSTART: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (nres.done) begin
						scan_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (scan_q == ccount_q) begin
						state_q <= S_NEXT;
					end else if (!ent_match) begin
						scan_q <= scan_q + 1'b1;
					end else if (out_free) begin
						out_id_q    <= sid_q[ent];
						out_x_q     <= nres.qx;
						out_y_q     <= nres.qy;
						out_z_q     <= nres.qz;
						out_last_q  <= (gsel_q + 1'b1 == gcount_q) && (ent == lastc_q);
						scan_q      <= scan_q + 1'b1;
					end
				end
				S_NEXT: begin
					gsel_q <= gsel_q + 1'b1;
					if (gsel_q + 1'b1 == gcount_q) begin
						gcount_q <= '0;
						ccount_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_NSTART;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready         = state_q == S_IDLE;
	assign out_valid        = out_valid_q;
	assign out_corner_index = out_id_q;
	assign tangent_x        = out_x_q;
	assign tangent_y        = out_y_q;
	assign tangent_z        = out_z_q;
	assign last_result      = out_last_q;

endmodule

/* design/usm_checker.sv */
module usm_checker import usm_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [CORNER_ID_BITS-1:0] out_corner_index,
	input logic signed [Q_W-1:0]     tangent_x,
	input logic signed [Q_W-1:0]     tangent_y,
	input logic signed [Q_W-1:0]     tangent_z,
	input logic                      last_result
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_corner_index) && $stable(tangent_x)
			&& $stable(tangent_y) && $stable(tangent_z) && $stable(last_result))
		else $error("result changed while stalled");

	// one corner item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous one is in work");

	// results only appear while a vertex is being flushed
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("result appeared outside a flush");

endmodule

bind uv_seam_tangent_merge usm_checker u_usm_checker (.*);
